### sv/integer_nth_root_macros.svh
// ----------------------------------------------------------------------------
// integer nth root assertion macros
// shared property forms for the checker, clocked on clk, reset rst
// ----------------------------------------------------------------------------
`ifndef INTEGER_NTH_ROOT_MACROS_SVH
`define INTEGER_NTH_ROOT_MACROS_SVH

// same-cycle implication, off during reset
`define INRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define INRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define INRT_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/inrt_pkg.sv
// ----------------------------------------------------------------------------
// inrt_pkg
// widths, micro-op codes, jump conditions and step addresses of the
// integer nth root sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package inrt_pkg;

  localparam int DW      = 32;
  localparam int DEG_W   = 5;
  localparam int ECNT_W  = 3;
  localparam int PC_W    = 5;
  localparam int IN_TDATA_W  = ((DW + DEG_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DW + 7) / 8) * 8;

  typedef logic [DW-1:0]     word_t;
  typedef logic [DEG_W-1:0]  deg_t;
  typedef logic [ECNT_W-1:0] ecnt_t;
  typedef logic [PC_W-1:0]   step_t;
  typedef logic [3:0]        op_t;
  typedef logic [3:0]        cond_t;

  // saturation level of every product
  localparam word_t SAT_CAP = word_t'(1) << (DW - 1);

  // datapath micro-ops
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_SPEC  = 4'd2;
  localparam op_t OP_PINIT = 4'd3;
  localparam op_t OP_SQR   = 4'd4;
  localparam op_t OP_MULV  = 4'd5;
  localparam op_t OP_DBL   = 4'd6;
  localparam op_t OP_RESV  = 4'd7;
  localparam op_t OP_HALF  = 4'd8;
  localparam op_t OP_SETTP = 4'd9;
  localparam op_t OP_ADDB  = 4'd10;
  localparam op_t OP_ACC   = 4'd11;
  localparam op_t OP_EMIT  = 4'd12;

  // jump conditions
  localparam cond_t COND_NEVER    = 4'd0;
  localparam cond_t COND_ALWAYS   = 4'd1;
  localparam cond_t COND_NO_INPUT = 4'd2;
  localparam cond_t COND_SPECIAL  = 4'd3;
  localparam cond_t COND_ECNT_NZ  = 4'd4;
  localparam cond_t COND_R_GE_A   = 4'd5;
  localparam cond_t COND_R_EQ_A   = 4'd6;
  localparam cond_t COND_STOP     = 4'd7;
  localparam cond_t COND_OUT_BUSY = 4'd8;

  // program addresses
  localparam step_t STEP_IDLE    = 5'd0;
  localparam step_t STEP_SPEC    = 5'd1;
  localparam step_t STEP_D_PINIT = 5'd2;
  localparam step_t STEP_D_SQR   = 5'd3;
  localparam step_t STEP_D_MUL   = 5'd4;
  localparam step_t STEP_D_TEST  = 5'd5;
  localparam step_t STEP_D_DBL   = 5'd6;
  localparam step_t STEP_D_HIT   = 5'd7;
  localparam step_t STEP_HALF    = 5'd8;
  localparam step_t STEP_H_PINIT = 5'd9;
  localparam step_t STEP_H_SQR   = 5'd10;
  localparam step_t STEP_H_MUL   = 5'd11;
  localparam step_t STEP_SETTP   = 5'd12;
  localparam step_t STEP_CHECK   = 5'd13;
  localparam step_t STEP_ADDB    = 5'd14;
  localparam step_t STEP_R_PINIT = 5'd15;
  localparam step_t STEP_R_SQR   = 5'd16;
  localparam step_t STEP_R_MUL   = 5'd17;
  localparam step_t STEP_ACC     = 5'd18;
  localparam step_t STEP_FINISH  = 5'd19;
  localparam step_t STEP_EMIT    = 5'd20;
  localparam step_t STEP_DONE    = 5'd21;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic special;
    logic ecnt_nz;
    logic r_ge_a;
    logic r_eq_a;
    logic stop;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

### sv/integer_nth_root.sv
// ----------------------------------------------------------------------------
// integer_nth_root
// largest integer whose degree-th power does not exceed a signed value,
// by doubling then bitwise refinement on a microcoded sequencer
// ----------------------------------------------------------------------------
//  channel  | direction | tdata bits (low to high)              | tuser / tlast
//  s_axis   | in        | value[31:0], degree[36:32], zero pad  | none
//  m_axis   | out       | root_out[31:0]                        | none
//
// one transaction at a time; every power is taken on the single shared
// saturating multiplier, in the doubling search, after the step back and in
// each refinement step; degree below two or a non-positive value skips all
// of the search and goes straight to the result
// the next input is taken while a result still waits in the output register
// rst is synchronous and clears the step counter and output valid only
// ----------------------------------------------------------------------------
`default_nettype none

module integer_nth_root (
  input  var logic                                  clk,
  input  var logic                                  rst,
  input  var logic                                  s_axis_tvalid,
  output logic                                      s_axis_tready,
  // value[31:0], degree[36:32], zero pad
  input  var logic [inrt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  var logic                                  m_axis_tready,
  // root_out[31:0]
  output logic [inrt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

  inrt_pkg::status_t status;
  inrt_pkg::op_t     op;
  inrt_pkg::word_t   root;
  logic              in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  inrt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .in_ready (s_axis_tready),
    .op       (op)
  );

  inrt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_fire   (in_fire),
    .value     (s_axis_tdata[inrt_pkg::DW-1:0]),
    .degree    (s_axis_tdata[inrt_pkg::DW+inrt_pkg::DEG_W-1:inrt_pkg::DW]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (root),
    .status    (status)
  );

  assign m_axis_tdata = inrt_pkg::OUT_TDATA_W'(root);

endmodule

`default_nettype wire

### sv/inrt_rom.sv
// ----------------------------------------------------------------------------
// inrt_rom
// microcode table: one control word per program step
// ----------------------------------------------------------------------------
`default_nettype none

module inrt_rom (
  input  var inrt_pkg::step_t pc,
  output inrt_pkg::ctrl_t     ctrl
);

  always_comb begin
    unique case (pc)
      inrt_pkg::STEP_IDLE:    ctrl = '{inrt_pkg::OP_LOAD,  inrt_pkg::COND_NO_INPUT,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_SPEC:    ctrl = '{inrt_pkg::OP_SPEC,  inrt_pkg::COND_SPECIAL,
                                       inrt_pkg::STEP_EMIT};
      // doubling search: power of the guess
      inrt_pkg::STEP_D_PINIT: ctrl = '{inrt_pkg::OP_PINIT, inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_D_SQR:   ctrl = '{inrt_pkg::OP_SQR,   inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_D_MUL:   ctrl = '{inrt_pkg::OP_MULV,  inrt_pkg::COND_ECNT_NZ,
                                       inrt_pkg::STEP_D_SQR};
      inrt_pkg::STEP_D_TEST:  ctrl = '{inrt_pkg::OP_NOP,   inrt_pkg::COND_R_GE_A,
                                       inrt_pkg::STEP_D_HIT};
      inrt_pkg::STEP_D_DBL:   ctrl = '{inrt_pkg::OP_DBL,   inrt_pkg::COND_ALWAYS,
                                       inrt_pkg::STEP_D_PINIT};
      inrt_pkg::STEP_D_HIT:   ctrl = '{inrt_pkg::OP_RESV,  inrt_pkg::COND_R_EQ_A,
                                       inrt_pkg::STEP_EMIT};
      // step back one octave and take its power
      inrt_pkg::STEP_HALF:    ctrl = '{inrt_pkg::OP_HALF,  inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_H_PINIT: ctrl = '{inrt_pkg::OP_PINIT, inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_H_SQR:   ctrl = '{inrt_pkg::OP_SQR,   inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_H_MUL:   ctrl = '{inrt_pkg::OP_MULV,  inrt_pkg::COND_ECNT_NZ,
                                       inrt_pkg::STEP_H_SQR};
      inrt_pkg::STEP_SETTP:   ctrl = '{inrt_pkg::OP_SETTP, inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      // bitwise refinement loop
      inrt_pkg::STEP_CHECK:   ctrl = '{inrt_pkg::OP_NOP,   inrt_pkg::COND_STOP,
                                       inrt_pkg::STEP_FINISH};
      inrt_pkg::STEP_ADDB:    ctrl = '{inrt_pkg::OP_ADDB,  inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_R_PINIT: ctrl = '{inrt_pkg::OP_PINIT, inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_R_SQR:   ctrl = '{inrt_pkg::OP_SQR,   inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_R_MUL:   ctrl = '{inrt_pkg::OP_MULV,  inrt_pkg::COND_ECNT_NZ,
                                       inrt_pkg::STEP_R_SQR};
      inrt_pkg::STEP_ACC:     ctrl = '{inrt_pkg::OP_ACC,   inrt_pkg::COND_ALWAYS,
                                       inrt_pkg::STEP_CHECK};
      inrt_pkg::STEP_FINISH:  ctrl = '{inrt_pkg::OP_RESV,  inrt_pkg::COND_NEVER,
                                       inrt_pkg::STEP_IDLE};
      inrt_pkg::STEP_EMIT:    ctrl = '{inrt_pkg::OP_EMIT,  inrt_pkg::COND_OUT_BUSY,
                                       inrt_pkg::STEP_EMIT};
      inrt_pkg::STEP_DONE:    ctrl = '{inrt_pkg::OP_NOP,   inrt_pkg::COND_ALWAYS,
                                       inrt_pkg::STEP_IDLE};
      default:                ctrl = '{inrt_pkg::OP_NOP,   inrt_pkg::COND_ALWAYS,
                                       inrt_pkg::STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

### sv/inrt_dp.sv
// ----------------------------------------------------------------------------
// inrt_dp
// datapath: guess, step bit, power accumulator on one saturating multiplier,
// and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module inrt_dp (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var inrt_pkg::op_t        op,
  input  var logic                 in_fire,
  input  var inrt_pkg::word_t      value,
  input  var inrt_pkg::deg_t       degree,
  input  var logic                 out_ready,
  output logic                     out_valid,
  output inrt_pkg::word_t          out_data,
  output inrt_pkg::status_t        status
);

  inrt_pkg::word_t a;
  inrt_pkg::deg_t  deg;
  inrt_pkg::ecnt_t emsb;
  inrt_pkg::ecnt_t ecnt;
  inrt_pkg::word_t v;
  inrt_pkg::word_t c;
  inrt_pkg::word_t bitv;
  inrt_pkg::word_t tp;
  inrt_pkg::word_t r;
  inrt_pkg::word_t res;

  inrt_pkg::word_t             mul_b;
  logic [2*inrt_pkg::DW-1:0]   prod;
  inrt_pkg::word_t             prod_sat;
  inrt_pkg::ecnt_t             deg_msb;

  // top set bit of the degree, where the left-to-right power starts
  always_comb begin
    deg_msb = '0;
    for (int i = 0; i < inrt_pkg::DEG_W; i++) begin
      if (degree[i]) begin
        deg_msb = inrt_pkg::ecnt_t'(i);
      end
    end
  end

  assign mul_b    = (op == inrt_pkg::OP_SQR) ? r : c;
  assign prod     = {{inrt_pkg::DW{1'b0}}, r} * {{inrt_pkg::DW{1'b0}}, mul_b};
  assign prod_sat = (prod > {{inrt_pkg::DW{1'b0}}, inrt_pkg::SAT_CAP})
                    ? inrt_pkg::SAT_CAP : prod[inrt_pkg::DW-1:0];

  always_ff @(posedge clk) begin
    unique case (op) inside
      inrt_pkg::OP_LOAD: begin
        if (in_fire) begin
          a    <= value;
          deg  <= degree;
          emsb <= deg_msb;
          v    <= inrt_pkg::word_t'(1);
          c    <= inrt_pkg::word_t'(1);
        end
      end
      inrt_pkg::OP_SPEC:  res <= (deg == inrt_pkg::deg_t'(1)) ? a : '0;
      inrt_pkg::OP_PINIT: begin
        r    <= inrt_pkg::word_t'(1);
        ecnt <= emsb;
      end
      inrt_pkg::OP_SQR:   r <= prod_sat;
      inrt_pkg::OP_MULV: begin
        if (deg[ecnt]) begin
          r <= prod_sat;
        end
        ecnt <= ecnt - inrt_pkg::ecnt_t'(1);
      end
      inrt_pkg::OP_DBL: begin
        v <= v << 1;
        c <= v << 1;
      end
      inrt_pkg::OP_RESV:  res <= v;
      inrt_pkg::OP_HALF: begin
        v    <= v >> 1;
        c    <= v >> 1;
        bitv <= v >> 2;
      end
      inrt_pkg::OP_SETTP: tp <= r;
      inrt_pkg::OP_ADDB:  c <= v + bitv;
      inrt_pkg::OP_ACC: begin
        // keep the trial bit only while its power stays within the value
        if (r <= a) begin
          v  <= c;
          tp <= r;
        end
        bitv <= bitv >> 1;
      end
      inrt_pkg::OP_NOP, inrt_pkg::OP_EMIT: ;
      default: ;
    endcase
  end

  // output register, freed by the downstream side independently of the program
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (op == inrt_pkg::OP_EMIT && !status.out_busy) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == inrt_pkg::OP_EMIT && !status.out_busy) begin
      out_data <= res;
    end
  end

  always_comb begin
    status.special  = (deg < inrt_pkg::deg_t'(2)) || a[inrt_pkg::DW-1] || (a == '0);
    status.ecnt_nz  = (ecnt != '0);
    status.r_ge_a   = (r >= a);
    status.r_eq_a   = (r == a);
    status.stop     = (tp >= a) || (bitv == '0);
    status.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

### sv/inrt_seq.sv
// ----------------------------------------------------------------------------
// inrt_seq
// step counter with conditional jumps over the microcode table
// ----------------------------------------------------------------------------
`default_nettype none

module inrt_seq (
  input  var logic              clk,
  input  var logic              rst,
  input  var logic              in_valid,
  input  var inrt_pkg::status_t status,
  output logic                  in_ready,
  output inrt_pkg::op_t         op
);

  inrt_pkg::step_t pc;
  inrt_pkg::step_t pc_next;
  inrt_pkg::ctrl_t ctrl;
  logic            take;

  inrt_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      inrt_pkg::COND_NEVER:    take = 1'b0;
      inrt_pkg::COND_ALWAYS:   take = 1'b1;
      inrt_pkg::COND_NO_INPUT: take = !in_valid;
      inrt_pkg::COND_SPECIAL:  take = status.special;
      inrt_pkg::COND_ECNT_NZ:  take = status.ecnt_nz;
      inrt_pkg::COND_R_GE_A:   take = status.r_ge_a;
      inrt_pkg::COND_R_EQ_A:   take = status.r_eq_a;
      inrt_pkg::COND_STOP:     take = status.stop;
      inrt_pkg::COND_OUT_BUSY: take = status.out_busy;
      default:                 take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + inrt_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= inrt_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready = (pc == inrt_pkg::STEP_IDLE);
  assign op       = ctrl.op;

endmodule

`default_nettype wire

### sv/inrt_checker.sv
// ----------------------------------------------------------------------------
// inrt_checker
// port-level checks of the integer nth root block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_nth_root_macros.svh"

module inrt_checker (
  input var logic                             clk,
  input var logic                             rst,
  input var logic                             s_axis_tvalid,
  input var logic                             s_axis_tready,
  input var logic                             m_axis_tvalid,
  input var logic                             m_axis_tready,
  input var logic [inrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a result held back keeps its valid
  `INRT_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its value
  `INRT_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled result changed")

  // one transaction at a time: input closes right after an accept
  `INRT_ASSERT_NEXT(a_in_close, in_fire, !s_axis_tready, "input taken twice in a row")

  // a new result only appears while the input side is busy
  `INRT_ASSERT_NOW(a_out_rise, $rose(m_axis_tvalid), $past(!s_axis_tready), "stray result")

  // reset empties the output register
  `INRT_ASSERT_ALWAYS(a_rst_out, rst, !m_axis_tvalid, "output valid after reset")

endmodule

bind integer_nth_root inrt_checker u_inrt_checker (.*);

`default_nettype wire

### sim/integer_nth_root_tb.sv
// ----------------------------------------------------------------------------
// integer_nth_root_tb
// streams radicand/degree pairs through the nth root block and compares each
// root with a saturating-power bitwise search computed alongside, with random
// idling on both channels and two long output hold-offs
// ----------------------------------------------------------------------------
`default_nettype none

module integer_nth_root_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int              ITEM_TOTAL     = 1700;
  localparam int              QUIET_TAIL     = 150;
  localparam int              LONG_STALL     = 800;
  localparam int              DRAIN_CYCLES   = 400;
  localparam int              WATCHDOG_LIMIT = 5000;
  localparam int              REPORT_MAX     = 10;
  localparam logic [63:0]     POW_CAP        = 64'd1 << (inrt_pkg::DW - 1);
  localparam inrt_pkg::word_t WORD_MAX       = {1'b0, {(inrt_pkg::DW-1){1'b1}}};
  localparam inrt_pkg::word_t WORD_MIN       = {1'b1, {(inrt_pkg::DW-1){1'b0}}};

  typedef struct packed {
    inrt_pkg::word_t value;
    inrt_pkg::deg_t  degree;
  } root_req_t;

  typedef struct packed {
    inrt_pkg::word_t value;
    inrt_pkg::deg_t  degree;
    inrt_pkg::word_t root;
  } root_expect_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [inrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [inrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  root_req_t    pending_items[$];
  root_expect_t expected_roots[$];

  logic         in_taken = 1'b0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           tx_mode = 1;
  int           rx_mode = 1;
  int           stall_left = 0;
  int           stalls_done = 0;
  int           quiet_cycles = 0;
  int           cycle_no = 0;
  int           results_checked = 0;
  int           items_taken = 0;
  int           nonpos_items = 0;
  int           error_count = 0;
  logic [31:0]  degrees_seen = '0;

  integer_nth_root dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // products clamp at 2^(DW-1); inputs never exceed that, so 64 bits suffice
  function automatic logic [63:0] sat_product(logic [63:0] x, logic [63:0] y);
    logic [63:0] p;
    if (x == 0 || y == 0) return 64'd0;
    p = x * y;
    return (p > POW_CAP) ? POW_CAP : p;
  endfunction

  function automatic logic [63:0] sat_power(logic [63:0] base, inrt_pkg::deg_t degree);
    logic [63:0]    acc;
    logic [63:0]    sq;
    inrt_pkg::deg_t e;
    acc = 64'd1;
    sq  = (base > POW_CAP) ? POW_CAP : base;
    e   = degree;
    while (e != 0) begin
      if (e[0]) acc = sat_product(acc, sq);
      e = e >> 1;
      if (e != 0) sq = sat_product(sq, sq);
    end
    return acc;
  endfunction

  // doubling search followed by high-to-low bit refinement
  function automatic inrt_pkg::word_t expected_root(inrt_pkg::word_t value,
                                                    inrt_pkg::deg_t degree);
    logic [63:0] a;
    logic [63:0] guess;
    logic [63:0] step_bit;
    logic [63:0] tp;
    logic [63:0] trial;
    if (degree == 0) return '0;
    if (degree == 1) return value;
    if (value[inrt_pkg::DW-1] || value == 0) return '0;
    a     = 64'(value);
    guess = 64'd1;
    tp    = sat_power(guess, degree);
    while (tp < a) begin
      guess = guess << 1;
      tp    = sat_power(guess, degree);
    end
    if (tp == a) return guess[inrt_pkg::DW-1:0];
    guess    = guess >> 1;
    step_bit = guess >> 1;
    tp       = sat_power(guess, degree);
    while (a > tp && step_bit != 0) begin
      guess = guess + step_bit;
      trial = sat_power(guess, degree);
      if (trial > a) guess = guess - step_bit;
      else tp = trial;
      step_bit = step_bit >> 1;
    end
    return guess[inrt_pkg::DW-1:0];
  endfunction

  function automatic void queue_item(inrt_pkg::word_t value, inrt_pkg::deg_t degree);
    root_req_t req;
    req.value  = value;
    req.degree = degree;
    pending_items.push_back(req);
  endfunction

  function automatic logic idle_start(int mode);
    if (mode == 0) return 1'b0;
    if (mode == 1) return ($urandom_range(0, 7) == 0);
    return ($urandom_range(0, 2) == 0);
  endfunction

  // sender: holds a transaction until taken, idles in short random bursts
  always @(negedge clk) begin
    root_req_t                       req;
    logic [inrt_pkg::IN_TDATA_W-1:0] word;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (cycle_no % 256 == 0) tx_mode <= $urandom_range(0, 2);
      if (s_axis_tvalid && !in_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (tx_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap        <= tx_gap - 1;
      end else if (pending_items.size() > QUIET_TAIL && idle_start(tx_mode)) begin
        s_axis_tvalid <= 1'b0;
        tx_gap        <= $urandom_range(0, 3);
      end else if (pending_items.size() != 0) begin
        req                  = pending_items.pop_front();
        word                 = '0;
        word[inrt_pkg::DW-1:0] = req.value;
        word[inrt_pkg::DW+inrt_pkg::DEG_W-1:inrt_pkg::DW] = req.degree;
        s_axis_tdata         <= word;
        s_axis_tvalid        <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure bursts plus the long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (cycle_no % 256 == 128) rx_mode <= $urandom_range(0, 2);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_gap        <= rx_gap - 1;
      end else if (pending_items.size() > QUIET_TAIL && idle_start(rx_mode)) begin
        m_axis_tready <= 1'b0;
        rx_gap        <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long hold-off of the output while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_done < 2 &&
                 results_checked >= ((stalls_done == 0) ? 100 : 900)) begin
      stall_left  <= LONG_STALL;
      stalls_done <= stalls_done + 1;
    end
  end

  // result checking and expectation bookkeeping
  always @(posedge clk) begin
    root_expect_t    exp_item;
    root_expect_t    got_item;
    inrt_pkg::word_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[inrt_pkg::DW-1:0];
        if (expected_roots.size() == 0) begin
          if (error_count < REPORT_MAX)
            $display("[%0t] root 0x%08h arrived with nothing outstanding", $realtime, got);
          error_count = error_count + 1;
        end else begin
          exp_item = expected_roots.pop_front();
          if (got !== exp_item.root) begin
            if (error_count < REPORT_MAX)
              $display("[%0t] root mismatch: value %0d degree %0d expected %0d got %0d",
                       $realtime, $signed(exp_item.value), exp_item.degree,
                       $signed(exp_item.root), $signed(got));
            error_count = error_count + 1;
          end
          results_checked <= results_checked + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_item.value  = s_axis_tdata[inrt_pkg::DW-1:0];
        got_item.degree = s_axis_tdata[inrt_pkg::DW+inrt_pkg::DEG_W-1:inrt_pkg::DW];
        got_item.root   = expected_root(got_item.value, got_item.degree);
        expected_roots.push_back(got_item);
        items_taken  <= items_taken + 1;
        degrees_seen[got_item.degree] <= 1'b1;
        if (got_item.value[inrt_pkg::DW-1] || got_item.value == 0)
          nonpos_items <= nonpos_items + 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int              n;
    int              pick;
    int              off;
    inrt_pkg::deg_t  d;
    inrt_pkg::word_t v;
    inrt_pkg::word_t max_r;
    inrt_pkg::word_t r;
    logic [63:0]     p;

    // directed corners: degree zero and one, non-positive values, exact powers
    queue_item(WORD_MIN, 5'd0);
    queue_item(WORD_MAX, 5'd0);
    queue_item('1, 5'd1);
    queue_item(WORD_MIN, 5'd1);
    queue_item(WORD_MAX, 5'd1);
    queue_item('0, 5'd2);
    queue_item('1, 5'd2);
    queue_item(WORD_MIN, 5'd31);
    queue_item(inrt_pkg::word_t'(1), 5'd2);
    queue_item(inrt_pkg::word_t'(2), 5'd2);
    queue_item(inrt_pkg::word_t'(3), 5'd2);
    queue_item(inrt_pkg::word_t'(4), 5'd2);
    queue_item(WORD_MAX, 5'd2);
    queue_item(inrt_pkg::word_t'(2147395600), 5'd2);
    queue_item(inrt_pkg::word_t'(2147395599), 5'd2);
    queue_item(inrt_pkg::word_t'(26), 5'd3);
    queue_item(inrt_pkg::word_t'(27), 5'd3);
    queue_item(inrt_pkg::word_t'(28), 5'd3);
    queue_item(WORD_MAX, 5'd31);
    queue_item(inrt_pkg::word_t'(32'h4000_0000), 5'd30);
    queue_item(inrt_pkg::word_t'(32'h3fff_ffff), 5'd30);
    queue_item(WORD_MAX, 5'd16);
    queue_item(inrt_pkg::word_t'(3125), 5'd5);
    queue_item(inrt_pkg::word_t'(1), 5'd31);

    n = pending_items.size();
    while (n < ITEM_TOTAL) begin
      pick = $urandom_range(0, 9);
      d = ($urandom_range(0, 3) == 0) ? inrt_pkg::deg_t'($urandom_range(0, 31))
                                      : inrt_pkg::deg_t'($urandom_range(2, 6));
      case (pick)
        0, 1, 2: v = $urandom;
        3, 4:    v = inrt_pkg::word_t'($urandom_range(0, 1000));
        5, 6: begin
          // near an exact power
          d     = inrt_pkg::deg_t'($urandom_range(2, 31));
          max_r = expected_root(WORD_MAX, d);
          r     = inrt_pkg::word_t'($urandom_range(0, max_r));
          p     = sat_power(64'(r), d);
          off   = $urandom_range(0, 2) - 1;
          v     = p[inrt_pkg::DW-1:0] + inrt_pkg::word_t'(off);
        end
        7:       v = $urandom >> $urandom_range(1, 31);
        8: begin
          case ($urandom_range(0, 5))
            0:       v = WORD_MAX;
            1:       v = WORD_MIN;
            2:       v = '1;
            3:       v = '0;
            4:       v = inrt_pkg::word_t'(1);
            default: v = inrt_pkg::word_t'(2);
          endcase
        end
        default: v = -inrt_pkg::word_t'($urandom_range(1, 5000));
      endcase
      queue_item(v, d);
      n = n + 1;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d roots checked, %0d of them with a non-positive radicand",
             items_taken, results_checked, nonpos_items);
    $display("%0d of 32 degree values used, %0d output hold-offs of %0d cycles",
             $countones(degrees_seen), stalls_done, LONG_STALL);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### integer_nth_root.f
+incdir+sv
sv/inrt_pkg.sv
sv/inrt_rom.sv
sv/inrt_dp.sv
sv/inrt_seq.sv
sv/integer_nth_root.sv
sv/inrt_checker.sv
sim/integer_nth_root_tb.sv
